### hdl/ffd_pkg.sv
// Shared types and constants for the fixed-length frame deframer.
// Used by ffd_cell and fixed_frame_deframer_sum16; depends on nothing.
package ffd_pkg;

  localparam int CELLS     = 23;  // stored window bytes; the 24th is the incoming word
  localparam int SUM_W     = 13;  // prefix sums of up to 24 bytes fit in 13 bits
  localparam int FILL_W    = 5;
  localparam logic [FILL_W-1:0] FILL_LAST = 5'd23;
  localparam logic [FILL_W-1:0] FILL_AFTER_DROP1 = 5'd23;
  localparam logic [FILL_W-1:0] FILL_AFTER_DROP2 = 5'd22;
  localparam logic [7:0] HEAD0 = 8'hBB;
  localparam logic [7:0] HEAD1 = 8'hAA;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_DROP1  = 2'd2;
  localparam logic [1:0] OP_DROP2  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       data;
    logic [SUM_W-1:0] sub;
  } cell_ctrl_t;

endpackage

### hdl/ffd_cell.sv
// One window cell: holds a byte and the running sum of all bytes up to it.
// Depends on ffd_pkg for the control struct and operation codes.
module ffd_cell (
  input  logic                    clk,
  input  ffd_pkg::cell_ctrl_t     ctrl,
  input  logic                    wr_sel,
  input  logic [ffd_pkg::SUM_W-1:0] prev_sum,
  input  logic [7:0]              nb1_byte,
  input  logic [ffd_pkg::SUM_W-1:0] nb1_sum,
  input  logic [7:0]              nb2_byte,
  input  logic [ffd_pkg::SUM_W-1:0] nb2_sum,
  output logic [7:0]              byte_q,
  output logic [ffd_pkg::SUM_W-1:0] sum_q
);
  import ffd_pkg::*;

  // A drop shifts the window toward the front; the prefix sums are rebased by
  // subtracting the sum of the bytes that leave.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_APPEND: begin
        if (wr_sel) begin
          byte_q <= ctrl.data;
          sum_q  <= prev_sum + {{(SUM_W-8){1'b0}}, ctrl.data};
        end
      end
      OP_DROP1: begin
        byte_q <= nb1_byte;
        sum_q  <= nb1_sum - ctrl.sub;
      end
      OP_DROP2: begin
        byte_q <= nb2_byte;
        sum_q  <= nb2_sum - ctrl.sub;
      end
      OP_HOLD: begin
      end
    endcase
  end

endmodule

### hdl/fixed_frame_deframer_sum16.sv
// Top level of the frame deframer: a row of window cells plus the frame check.
// Depends on ffd_pkg and ffd_cell.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   rx_byte
//   out      out_valid / out_ready addr_byte, command_code, reserved_byte,
//                                  length_byte, payload_low, payload_high
//
// One input word is taken per cycle; a frame appears on the output register in the
// cycle after its last word is taken. The check of a full window uses per-cell prefix
// sums, so only one 16-bit compare sits behind the last word. Reset empties the
// window at once. Input stalls only when the next word would complete a window
// while a frame is still waiting on the output.
module fixed_frame_deframer_sum16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  addr_byte,
  output logic [7:0]  command_code,
  output logic [7:0]  reserved_byte,
  output logic [7:0]  length_byte,
  output logic [63:0] payload_low,
  output logic [63:0] payload_high
);
  import ffd_pkg::*;

  logic [FILL_W-1:0] fill, fill_next;
  logic [7:0]        cell_byte [CELLS];
  logic [SUM_W-1:0]  cell_sum  [CELLS];
  logic [7:0]        ext_byte  [CELLS+2];
  logic [SUM_W-1:0]  ext_sum   [CELLS+2];
  logic [CELLS-1:0]  wr_sel;
  cell_ctrl_t        ctrl;
  logic              accept, at_full, hdr_ok, sum_ok, frame_hit;

  assign accept  = in_valid & in_ready;
  assign at_full = (fill == FILL_LAST);
  assign in_ready = !at_full || !out_valid || out_ready;

  // The incoming word stands in as the window's last byte when it completes it.
  always_comb begin
    for (int j = 0; j < CELLS; j++) begin
      ext_byte[j] = cell_byte[j];
      ext_sum[j]  = cell_sum[j];
    end
    ext_byte[CELLS]   = rx_byte;
    ext_sum[CELLS]    = cell_sum[CELLS-1] + {{(SUM_W-8){1'b0}}, rx_byte};
    ext_byte[CELLS+1] = '0;
    ext_sum[CELLS+1]  = '0;
  end

  assign hdr_ok = (cell_byte[0] == HEAD0) && (cell_byte[1] == HEAD1);
  assign sum_ok = ({3'b000, cell_sum[21]} == {rx_byte, cell_byte[22]});
  assign frame_hit = accept && at_full && hdr_ok && sum_ok;

  always_comb begin
    ctrl.op   = OP_HOLD;
    ctrl.data = rx_byte;
    if (accept) begin
      priority if (!at_full) ctrl.op = OP_APPEND;
      else if (!hdr_ok)      ctrl.op = OP_DROP1;
      else if (!sum_ok)      ctrl.op = OP_DROP2;
      else                   ctrl.op = OP_HOLD;
    end
    ctrl.sub = (ctrl.op == OP_DROP1) ? cell_sum[0] : cell_sum[1];
  end

  always_comb begin
    fill_next = fill;
    if (accept) begin
      priority if (!at_full) fill_next = fill + 5'd1;
      else if (!hdr_ok)      fill_next = FILL_AFTER_DROP1;
      else if (!sum_ok)      fill_next = FILL_AFTER_DROP2;
      else                   fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  genvar g;
  generate
    for (g = 0; g < CELLS; g++) begin : g_cell
      assign wr_sel[g] = (fill == FILL_W'(g));
      ffd_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .wr_sel   (wr_sel[g]),
        .prev_sum ((g == 0) ? {SUM_W{1'b0}} : cell_sum[(g == 0) ? 0 : g-1]),
        .nb1_byte (ext_byte[g+1]),
        .nb1_sum  (ext_sum[g+1]),
        .nb2_byte (ext_byte[g+2]),
        .nb2_sum  (ext_sum[g+2]),
        .byte_q   (cell_byte[g]),
        .sum_q    (cell_sum[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_hit) begin
      addr_byte     <= cell_byte[2];
      command_code  <= cell_byte[3];
      reserved_byte <= cell_byte[4];
      length_byte   <= cell_byte[5];
      for (int k = 0; k < 8; k++) begin
        payload_low[8*k +: 8]  <= cell_byte[6 + k];
        payload_high[8*k +: 8] <= cell_byte[14 + k];
      end
    end
  end

endmodule

### sim/ffd_frame_checker.sv
// Frame checker for the fixed-length frame deframer: watches both channels,
// predicts the frames and compares them field by field. Depends on ffd_pkg.
`timescale 1ns / 100ps

module ffd_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  addr_byte,
  input  logic [7:0]  command_code,
  input  logic [7:0]  reserved_byte,
  input  logic [7:0]  length_byte,
  input  logic [63:0] payload_low,
  input  logic [63:0] payload_high,
  output int          fail_count,
  output int          frames_pending
);
  import ffd_pkg::*;

  localparam int FRAME_WORDS = 24;
  localparam int SUM_WORDS   = 22;

  typedef struct {
    logic [7:0]  addr;
    logic [7:0]  command;
    logic [7:0]  reserved;
    logic [7:0]  length;
    logic [63:0] pay_lo;
    logic [63:0] pay_hi;
  } frame_t;

  logic [7:0] window [0:FRAME_WORDS-1];
  int         fill;
  frame_t     expected_frames [$];
  frame_t     oldest;

  task automatic drop_front(input int n);
    int k;
    for (k = 0; k < fill - n; k++) window[k] = window[k + n];
    fill = fill - n;
  endtask

  // Appends one word to the window and, once it is full, checks it the way
  // the block does: header first, then the additive checksum.
  task automatic absorb_word(input logic [7:0] b);
    logic [15:0] sum;
    frame_t      f;
    int          k;
    window[fill] = b;
    fill++;
    if (fill < FRAME_WORDS) return;
    if (window[0] != HEAD0 || window[1] != HEAD1) begin
      drop_front(1);
      return;
    end
    sum = '0;
    for (k = 0; k < SUM_WORDS; k++) sum = sum + 16'(window[k]);
    if (window[22] != sum[7:0] || window[23] != sum[15:8]) begin
      drop_front(2);
      return;
    end
    f.addr     = window[2];
    f.command  = window[3];
    f.reserved = window[4];
    f.length   = window[5];
    for (k = 0; k < 8; k++) begin
      f.pay_lo[8*k +: 8] = window[6 + k];
      f.pay_hi[8*k +: 8] = window[14 + k];
    end
    expected_frames.push_back(f);
    fill = 0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      expected_frames.delete();
    end else begin
      if (in_valid && in_ready) absorb_word(rx_byte);
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: frame expected none, got addr %0h command %0h", $time,
                   addr_byte, command_code);
          fail_count++;
        end else begin
          oldest = expected_frames.pop_front();
          check_field("addr_byte", 64'(oldest.addr), 64'(addr_byte));
          check_field("command_code", 64'(oldest.command), 64'(command_code));
          check_field("reserved_byte", 64'(oldest.reserved), 64'(reserved_byte));
          check_field("length_byte", 64'(oldest.length), 64'(length_byte));
          check_field("payload_low", oldest.pay_lo, payload_low);
          check_field("payload_high", oldest.pay_hi, payload_high);
        end
      end
    end
    frames_pending = expected_frames.size();
  end

endmodule

### sim/fixed_frame_deframer_sum16_tb.sv
// Testbench top for fixed_frame_deframer_sum16: drives framed, broken and
// noisy byte streams and gives the verdict. Depends on ffd_pkg and ffd_frame_checker.
`timescale 1ns / 100ps

module fixed_frame_deframer_sum16_tb;
  import ffd_pkg::*;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_t;
  typedef enum {FLAW_NONE, FLAW_HEAD0, FLAW_HEAD1, FLAW_SUM_LO, FLAW_SUM_HI,
                FLAW_SHORT} flaw_t;

  localparam int WORD_TARGET = 1700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  addr_byte, command_code, reserved_byte, length_byte;
  logic [63:0] payload_low, payload_high;
  logic        calm = 1'b0;
  int          fail_count, frames_pending;
  int          words_sent = 0;
  logic [7:0]  frame_buf [0:23];

  always #5 clk = ~clk;

  fixed_frame_deframer_sum16 dut (
    .clk, .rst, .in_valid, .in_ready, .rx_byte, .out_valid, .out_ready,
    .addr_byte, .command_code, .reserved_byte, .length_byte,
    .payload_low, .payload_high
  );

  ffd_frame_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .rx_byte, .out_valid, .out_ready,
    .addr_byte, .command_code, .reserved_byte, .length_byte,
    .payload_low, .payload_high, .fail_count, .frames_pending
  );

  // The receiver stalls at random (never while calm), now and then for a long stretch so
  // that a completed window has to wait behind an unread frame.
  initial begin
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(999) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(60, 30)) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= 27);
      end
    end
  end

  task automatic send_word(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Builds a frame with a correct header and checksum, spoils it as asked,
  // and sends it (only its head when the flaw is a short frame).
  task automatic send_frame(input fill_kind_t kind, input flaw_t flaw);
    logic [15:0] sum;
    int          k;
    int          count;
    frame_buf[0] = HEAD0;
    frame_buf[1] = HEAD1;
    for (k = 2; k < 22; k++) begin
      case (kind)
        FILL_ZERO: frame_buf[k] = 8'h00;
        FILL_ONES: frame_buf[k] = 8'hFF;
        default:   frame_buf[k] = 8'($urandom_range(255));
      endcase
    end
    sum = '0;
    for (k = 0; k < 22; k++) sum = sum + 16'(frame_buf[k]);
    frame_buf[22] = sum[7:0];
    frame_buf[23] = sum[15:8];
    case (flaw)
      FLAW_HEAD0:  frame_buf[0]  = frame_buf[0] ^ 8'($urandom_range(255, 1));
      FLAW_HEAD1:  frame_buf[1]  = frame_buf[1] ^ 8'($urandom_range(255, 1));
      FLAW_SUM_LO: frame_buf[22] = frame_buf[22] ^ 8'($urandom_range(255, 1));
      FLAW_SUM_HI: frame_buf[23] = frame_buf[23] ^ 8'($urandom_range(255, 1));
      default: ;
    endcase
    count = (flaw == FLAW_SHORT) ? $urandom_range(23, 1) : 24;
    for (k = 0; k < count; k++) send_word(frame_buf[k]);
  endtask

  // Loose bytes, with header values mixed in to tempt false syncs.
  task automatic send_noise(input int n);
    int k;
    int pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(7);
      if (pick == 0) send_word(HEAD0);
      else if (pick == 1) send_word(HEAD1);
      else send_word(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int pick;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_frame(FILL_ZERO, FLAW_NONE);
    send_frame(FILL_ONES, FLAW_NONE);
    send_frame(FILL_RANDOM, FLAW_HEAD0);
    send_frame(FILL_RANDOM, FLAW_HEAD1);
    send_frame(FILL_RANDOM, FLAW_SUM_LO);
    send_frame(FILL_RANDOM, FLAW_SUM_HI);
    send_frame(FILL_RANDOM, FLAW_SHORT);
    send_noise(5);
    send_frame(FILL_RANDOM, FLAW_NONE);
    send_frame(FILL_RANDOM, FLAW_NONE);

    while (words_sent < WORD_TARGET) begin
      calm <= (words_sent >= 700 && words_sent < 1000);
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(FILL_RANDOM, FLAW_NONE);
      end else if (pick < 85) begin
        send_frame(FILL_RANDOM, flaw_t'($urandom_range(FLAW_SHORT, FLAW_HEAD0)));
      end else if (pick < 95) begin
        send_noise($urandom_range(30, 1));
      end else begin
        send_frame($urandom_range(1) ? FILL_ZERO : FILL_ONES, FLAW_NONE);
      end
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (frames_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS fixed_frame_deframer_sum16");
    end else begin
      $display("FAIL fixed_frame_deframer_sum16");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL fixed_frame_deframer_sum16");
    $finish;
  end

endmodule

### fixed_frame_deframer_sum16.f
hdl/ffd_pkg.sv
hdl/ffd_cell.sv
hdl/fixed_frame_deframer_sum16.sv
sim/ffd_frame_checker.sv
sim/fixed_frame_deframer_sum16_tb.sv
